// ----- hdl/tclrq_pkg.sv -----
package tclrq_pkg;

	localparam int GAME_ENTRIES = 256;
	localparam int CACHE_SLOTS = 32;
	localparam int QUEUE_DEPTH = 16;
	localparam int GW = $clog2(GAME_ENTRIES);
	localparam int SW = $clog2(CACHE_SLOTS);
	localparam int QW = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		CMD_LOOKUP = 3'd0,
		CMD_TICK = 3'd1,
		CMD_FETCH = 3'd2,
		CMD_COMPLETE = 3'd3,
		CMD_SESSION = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_ABSENT = 2'd0,
		ST_PENDING = 2'd1,
		ST_RESIDENT = 2'd2,
		ST_BLANK = 2'd3
	} entry_st_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] game;
		logic load_ok;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [4:0] slot;
		logic enqueued;
		logic fetch_valid;
		logic [7:0] fetch_game;
		logic evicted_valid;
		logic [7:0] evicted_game;
		logic busy_res;
	} res_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_CLEAR,
		FS_RD,
		FS_EXEC,
		FS_SCAN,
		FS_SCAN_LAST,
		FS_VICT,
		FS_INST,
		FS_SESS,
		FS_OUT
	} fsm_t;

endpackage

// ----- hdl/tile_cache_lru_request_queue.sv -----
// A plain item passes through the read, execute and output states; an install into a free
// slot adds an install state, a complete that evicts first scans the stamp memory (one read
// per slot) and a new session sweeps every entry (one entry per cycle). One item at a time:
// the next item is taken only after the result is registered; a held result stalls the input
// only once the next is done. After reset a clearing pass sweeps all 256 entries of the entry
// memory before the first item is taken; configuration writes are taken throughout.
module tile_cache_lru_request_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tclrq_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output tclrq_pkg::res_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [8:0] cfg_data
);
	import tclrq_pkg::*;

	// entry word: {state, mapped, slot}
	localparam int EW = 2 + 1 + SW;

	logic [EW-1:0] emem [GAME_ENTRIES];
	logic [GW-1:0] ewa, era;
	logic [EW-1:0] ewd, erd_q;
	logic ewe;

	logic [31:0] smem [CACHE_SLOTS];
	logic [SW-1:0] swa, sra;
	logic [31:0] swd, srd_q;
	logic swe;

	logic [GW-1:0] omem [CACHE_SLOTS];
	logic [GW-1:0] ord_q;
	logic owe;

	logic [GW-1:0] ring [QUEUE_DEPTH];
	logic [GW-1:0] ring_rd;
	logic rwe;

	fsm_t st_q, st_d;
	req_t req_q;
	res_t res_q, res_d;
	res_t res_out_q;
	logic res_ld;
	logic [8:0] gcnt_q;
	logic [31:0] frame_q, frame_d;
	logic [SW:0] filled_q, filled_d;
	logic [QW-1:0] head_q, head_d, tail_q, tail_d;
	logic busy_q, busy_d;
	logic [GW:0] cnt_q, cnt_d;
	logic [31:0] best_q, best_d;
	logic [SW-1:0] bidx_q, bidx_d;
	logic [SW-1:0] ins_q, ins_d;
	logic out_v_q, out_v_d;
	logic load_req;

	always_ff @(posedge clk) begin
		if (ewe) emem[ewa] <= ewd;
		erd_q <= emem[era];
		if (swe) smem[swa] <= swd;
		srd_q <= smem[sra];
		if (owe) omem[ins_q] <= req_q.game;
		ord_q <= omem[sra];
		if (rwe) ring[tail_q] <= req_q.game;
	end
	assign ring_rd = ring[head_q];

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != FS_IDLE);
	assign out_valid = out_v_q;
	assign out_data = res_out_q;
	assign load_req = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FS_CLEAR;
			gcnt_q <= '0;
			frame_q <= '0;
			filled_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			busy_q <= 1'b0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid) gcnt_q <= cfg_data;
			frame_q <= frame_d;
			filled_q <= filled_d;
			head_q <= head_d;
			tail_q <= tail_d;
			busy_q <= busy_d;
			cnt_q <= cnt_d;
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) req_q <= in_data;
		res_q <= res_d;
		if (res_ld) res_out_q <= res_d;
		best_q <= best_d;
		bidx_q <= bidx_d;
		ins_q <= ins_d;
	end

	always_comb begin
		st_d = st_q;
		res_d = res_q;
		res_ld = 1'b0;
		frame_d = frame_q;
		filled_d = filled_q;
		head_d = head_q;
		tail_d = tail_q;
		busy_d = busy_q;
		cnt_d = cnt_q;
		best_d = best_q;
		bidx_d = bidx_q;
		ins_d = ins_q;
		out_v_d = out_v_q && out_stall;
		ewe = 1'b0;
		ewa = req_q.game;
		ewd = '0;
		era = req_q.game;
		swe = 1'b0;
		swa = ins_q;
		swd = frame_q;
		sra = cnt_q[SW-1:0];
		owe = 1'b0;
		rwe = 1'b0;
		unique case (st_q)
			FS_CLEAR: begin
				ewe = 1'b1;
				ewa = cnt_q[GW-1:0];
				ewd = {ST_ABSENT, 1'b0, {SW{1'b0}}};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == (GW+1)'(GAME_ENTRIES - 1)) begin
					cnt_d = '0;
					st_d = FS_IDLE;
				end
			end
			FS_IDLE: begin
				era = in_data.game;
				if (load_req) begin
					res_d = '0;
					st_d = FS_RD;
				end
			end
			FS_RD: st_d = FS_EXEC;
			FS_EXEC: begin
				st_d = FS_OUT;
				case (req_q.cmd)
					CMD_LOOKUP: begin
						if ({1'b0, req_q.game} < gcnt_q) begin
							if (erd_q[EW-1 -: 2] == ST_RESIDENT && erd_q[SW]) begin
								swe = 1'b1;
								swa = erd_q[SW-1:0];
								res_d.hit = 1'b1;
								res_d.slot = 5'(erd_q[SW-1:0]);
							end else if (erd_q[EW-1 -: 2] == ST_ABSENT &&
									QW'(tail_q + 1'b1) != head_q) begin
								rwe = 1'b1;
								tail_d = QW'(tail_q + 1'b1);
								ewe = 1'b1;
								ewd = {ST_PENDING, erd_q[SW:0]};
								res_d.enqueued = 1'b1;
							end
						end
					end
					CMD_TICK: frame_d = frame_q + 32'd1;
					CMD_FETCH: begin
						if (!busy_q && head_q != tail_q) begin
							head_d = QW'(head_q + 1'b1);
							busy_d = 1'b1;
							res_d.fetch_valid = 1'b1;
							res_d.fetch_game = 8'(ring_rd);
						end
					end
					CMD_COMPLETE: begin
						if (busy_q) begin
							busy_d = 1'b0;
							if (!req_q.load_ok) begin
								ewe = 1'b1;
								ewd = {ST_BLANK, erd_q[SW:0]};
							end else if (filled_q < (SW+1)'(CACHE_SLOTS)) begin
								ins_d = filled_q[SW-1:0];
								filled_d = filled_q + 1'b1;
								st_d = FS_INST;
							end else begin
								cnt_d = '0;
								sra = '0;
								st_d = FS_SCAN;
							end
						end
					end
					CMD_SESSION: begin
						head_d = '0;
						tail_d = '0;
						cnt_d = '0;
						era = '0;
						st_d = FS_SESS;
					end
					CMD_CLEAR: begin
						head_d = '0;
						tail_d = '0;
					end
					default: ;
				endcase
			end
			FS_SCAN: begin
				// srd_q holds stamp of slot cnt_q
				if (cnt_q == '0 || srd_q < best_q) begin
					best_d = srd_q;
					bidx_d = cnt_q[SW-1:0];
				end
				cnt_d = cnt_q + 1'b1;
				sra = SW'(cnt_q + 1'b1);
				if (cnt_q == (GW+1)'(CACHE_SLOTS - 1)) st_d = FS_SCAN_LAST;
			end
			FS_SCAN_LAST: begin
				sra = bidx_q;
				ins_d = bidx_q;
				st_d = FS_VICT;
			end
			FS_VICT: begin
				ewe = 1'b1;
				ewa = ord_q;
				ewd = {ST_ABSENT, 1'b0, {SW{1'b0}}};
				res_d.evicted_valid = 1'b1;
				res_d.evicted_game = 8'(ord_q);
				st_d = FS_INST;
			end
			FS_INST: begin
				swe = 1'b1;
				owe = 1'b1;
				ewe = 1'b1;
				ewd = {ST_RESIDENT, 1'b1, ins_q};
				res_d.slot = 5'(ins_q);
				st_d = FS_OUT;
			end
			FS_SESS: begin
				// erd_q holds entry cnt_q; read the next one
				era = GW'(cnt_q + 1'b1);
				cnt_d = cnt_q + 1'b1;
				if (erd_q[EW-1 -: 2] == ST_PENDING) begin
					ewe = 1'b1;
					ewa = cnt_q[GW-1:0];
					ewd = {ST_ABSENT, erd_q[SW:0]};
				end
				if (cnt_q == (GW+1)'(GAME_ENTRIES - 1)) st_d = FS_OUT;
			end
			FS_OUT: begin
				res_d.busy_res = busy_q;
				if (!out_v_q || !out_stall) begin
					res_ld = 1'b1;
					out_v_d = 1'b1;
					st_d = FS_IDLE;
				end
			end
			default: st_d = FS_IDLE;
		endcase
	end
endmodule
